// ----- sv/ssk_pkg.sv -----
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared types, sizes and helpers for the Shell sort block with Knuth gaps.
// ----------------------------------------------------------------------------
package ssk_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int KEY_BITS  = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GAP,
        ST_HOLD,
        ST_CMP,
        ST_PLACE,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // next Knuth value, 3g + 1, one bit wider than the count
    function automatic logic [CNT_W:0] knuth_up(input cnt_t g);
        logic [CNT_W:0] sum;
        sum = {1'b0, g} + {g, 1'b0} + {{CNT_W{1'b0}}, 1'b1};
        return sum;
    endfunction

    // (g - 1) / 3 by reciprocal 43/128, exact for g - 1 below 128
    function automatic cnt_t knuth_down(input cnt_t g);
        logic [CNT_W-1:0] gm1;
        logic [CNT_W+5:0] prod;
        gm1  = g - cnt_t'(1);
        prod = {6'b0, gm1} * (CNT_W + 6)'(43);
        return cnt_t'(prod[CNT_W+5:7]);
    endfunction

    function automatic logic goes_before(input key_t a, input key_t b, input logic desc);
        return desc ? (a > b) : (a < b);
    endfunction

endpackage

// ----- sv/shell_sort_knuth_gaps_top.sv -----
// ----------------------------------------------------------------------------
// shell_sort_knuth_gaps_top
// Loads up to 64 keys, sorts them in place by Shell sort with Knuth gaps and
// streams them out.
// ----------------------------------------------------------------------------
// Keys are taken one beat per cycle while s_tvalid is high, up to the beat
// with tlast; keys beyond 64 are dropped and every result of that list
// carries tuser = 1. The sort then runs on a key memory with separate write
// and read addresses (one write and one registered read a cycle) under a
// small sequencer, with s_tready low. Each inserted key of a pass is read and
// held, compared with and shifted past one neighbour at a time, then written
// into place; each gap change passes through ST_NEXT. Results then stream out
// at one beat per cycle while m_tready is high; loading of the next list
// starts after the last result is placed in the output register.
// ----------------------------------------------------------------------------
module shell_sort_knuth_gaps_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: bit 0 = descending
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] key_value
    input  logic        s_tlast,     // is_last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] sorted_value
    output logic        m_tlast,     // last_out
    output logic        m_tuser      // [0] overflowed
);

    ssk_pkg::state_t state_reg, state_next;
    ssk_pkg::cnt_t   count_reg, count_next;
    ssk_pkg::cnt_t   gap_reg, gap_next;
    ssk_pkg::cnt_t   k_reg, k_next;
    ssk_pkg::cnt_t   pos_reg, pos_next;
    ssk_pkg::key_t   held_reg, held_next;
    logic            ovf_reg, ovf_next;
    logic            desc_reg;

    logic            m_valid_reg, m_valid_next;
    ssk_pkg::key_t   m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;
    logic            m_user_reg, m_user_next;

    ssk_pkg::key_t   key_store_mem [ssk_pkg::MAX_ITEMS];
    ssk_pkg::key_t   rd_data_reg;
    logic            rd_en, wr_en;
    ssk_pkg::idx_t   rd_addr, wr_addr;
    ssk_pkg::key_t   wr_data;

    logic            s_beat;
    logic            out_free;
    logic [ssk_pkg::CNT_W:0] gap_up;
    ssk_pkg::cnt_t   k_inc, pos_dn, gap_dn;

    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign gap_up   = ssk_pkg::knuth_up(gap_reg);
    assign gap_dn   = ssk_pkg::knuth_down(gap_reg);
    assign k_inc    = k_reg + ssk_pkg::cnt_t'(1);
    assign pos_dn   = pos_reg - gap_reg;

    assign s_tready = (state_reg == ssk_pkg::ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= key_store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssk_pkg::ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            desc_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                desc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        gap_reg    <= gap_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        held_reg   <= held_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        gap_next     = gap_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        rd_en        = 1'b0;
        rd_addr      = k_reg[ssk_pkg::IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = pos_reg[ssk_pkg::IDX_W-1:0];
        wr_data      = held_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ssk_pkg::ST_LOAD: begin
                wr_addr = count_reg[ssk_pkg::IDX_W-1:0];
                wr_data = s_tdata;
                if (s_beat) begin
                    if (count_reg < ssk_pkg::cnt_t'(ssk_pkg::MAX_ITEMS)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + ssk_pkg::cnt_t'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        gap_next   = ssk_pkg::cnt_t'(1);
                        state_next = ssk_pkg::ST_GAP;
                    end
                end
            end
            // climb the Knuth sequence to the largest value below the count
            ssk_pkg::ST_GAP: begin
                if (count_reg <= gap_reg) begin
                    state_next = ssk_pkg::ST_NEXT;
                end else if (gap_up < {1'b0, count_reg}) begin
                    gap_next = gap_up[ssk_pkg::CNT_W-1:0];
                end else begin
                    k_next     = gap_reg;
                    rd_en      = 1'b1;
                    rd_addr    = gap_reg[ssk_pkg::IDX_W-1:0];
                    state_next = ssk_pkg::ST_HOLD;
                end
            end
            ssk_pkg::ST_HOLD: begin
                held_next  = rd_data_reg;
                pos_next   = k_reg;
                rd_en      = 1'b1;
                rd_addr    = ssk_pkg::idx_t'(k_reg - gap_reg);
                state_next = ssk_pkg::ST_CMP;
            end
            ssk_pkg::ST_CMP: begin
                wr_en = 1'b1;
                if (ssk_pkg::goes_before(held_reg, rd_data_reg, desc_reg)) begin
                    // shift the neighbor up by one gap
                    wr_data  = rd_data_reg;
                    pos_next = pos_dn;
                    if (pos_dn >= gap_reg) begin
                        rd_en   = 1'b1;
                        rd_addr = ssk_pkg::idx_t'(pos_dn - gap_reg);
                    end else begin
                        state_next = ssk_pkg::ST_PLACE;
                    end
                end else begin
                    wr_data = held_reg;
                    if (k_inc < count_reg) begin
                        k_next     = k_inc;
                        rd_en      = 1'b1;
                        rd_addr    = k_inc[ssk_pkg::IDX_W-1:0];
                        state_next = ssk_pkg::ST_HOLD;
                    end else begin
                        state_next = ssk_pkg::ST_NEXT;
                    end
                end
            end
            ssk_pkg::ST_PLACE: begin
                wr_en   = 1'b1;
                wr_data = held_reg;
                if (k_inc < count_reg) begin
                    k_next     = k_inc;
                    rd_en      = 1'b1;
                    rd_addr    = k_inc[ssk_pkg::IDX_W-1:0];
                    state_next = ssk_pkg::ST_HOLD;
                end else begin
                    state_next = ssk_pkg::ST_NEXT;
                end
            end
            // no write in flight here, so a read anywhere sees settled data
            ssk_pkg::ST_NEXT: begin
                rd_en = 1'b1;
                if (gap_reg == ssk_pkg::cnt_t'(1)) begin
                    k_next     = '0;
                    rd_addr    = '0;
                    state_next = ssk_pkg::ST_EMIT;
                end else begin
                    gap_next   = gap_dn;
                    k_next     = gap_dn;
                    rd_addr    = gap_dn[ssk_pkg::IDX_W-1:0];
                    state_next = ssk_pkg::ST_HOLD;
                end
            end
            ssk_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_data_reg;
                    m_last_next  = (k_inc == count_reg);
                    m_user_next  = ovf_reg;
                    if (k_inc == count_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ssk_pkg::ST_LOAD;
                    end else begin
                        k_next  = k_inc;
                        rd_en   = 1'b1;
                        rd_addr = k_inc[ssk_pkg::IDX_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ssk_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Shell sort block with Knuth gaps: lists of keys
// go in, each list is sorted by a local Shell sort and every result beat is
// checked against it, in both sort orders and with overflowing lists.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIST_CAP   = ssk_pkg::MAX_ITEMS;
    localparam int STALL_MAX  = 20000;
    localparam int RAND_ITEMS = 40;    // at least this many random keys per phase, four phases

    typedef struct packed {
        ssk_pkg::key_t key;
        logic          last;
    } key_beat_t;

    typedef struct packed {
        ssk_pkg::key_t value;
        logic          last;
        logic          ovf;
    } sorted_beat_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    shell_sort_knuth_gaps_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expected results
    key_beat_t    keys_to_send[$];
    sorted_beat_t sorted_due[$];

    // local copy of the block state
    ssk_pkg::key_t list_keys [LIST_CAP];
    int   list_len     = 0;
    bit   list_dropped = 1'b0;
    bit   order_desc   = 1'b0;

    bit idle_on   = 1'b1;
    bit key_taken = 1'b0;
    int send_gap  = 0;
    int recv_gap  = 0;

    int beats_queued = 0;
    int beats_in     = 0;
    int beats_out    = 0;
    int lists_done   = 0;
    int lists_ovf    = 0;
    int desc_lists   = 0;
    int errors       = 0;
    int stall_cycles = 0;

    // in-place Shell sort of the stored list, gaps 1, 4, 13, 40 from the top
    function automatic void shell_sort_list(int n);
        int            gap;
        int            below;
        int            k;
        int            pos;
        ssk_pkg::key_t held;
        gap   = 0;
        below = 0;
        while (gap < n) begin
            below = gap;
            gap   = 3 * gap + 1;
        end
        gap = below;
        while (gap > 0) begin
            for (k = gap; k < n; k++) begin
                held = list_keys[k];
                pos  = k;
                while (pos >= gap && (order_desc ? (held > list_keys[pos-gap])
                                                 : (held < list_keys[pos-gap]))) begin
                    list_keys[pos] = list_keys[pos-gap];
                    pos -= gap;
                end
                list_keys[pos] = held;
            end
            gap = (gap - 1) / 3;
        end
    endfunction

    function automatic void load_key(ssk_pkg::key_t key, logic last);
        sorted_beat_t b;
        if (list_len < LIST_CAP) begin
            list_keys[list_len] = key;
            list_len++;
        end else begin
            list_dropped = 1'b1;
        end
        if (last) begin
            shell_sort_list(list_len);
            for (int i = 0; i < list_len; i++) begin
                b.value = list_keys[i];
                b.last  = (i == list_len - 1);
                b.ovf   = list_dropped;
                sorted_due.push_back(b);
            end
            lists_done++;
            if (list_dropped)
                lists_ovf++;
            if (order_desc)
                desc_lists++;
            list_len     = 0;
            list_dropped = 1'b0;
        end
    endfunction

    // monitor: both handshakes sampled at the rising edge
    always @(posedge aclk) begin
        sorted_beat_t want;
        if (aresetn) begin
            key_taken = s_tvalid && s_tready;
            if (key_taken) begin
                load_key(s_tdata, s_tlast);
                beats_in++;
            end
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (sorted_due.size() == 0) begin
                    $display("%0t: unexpected result beat key %h last %b ovf %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    errors++;
                end else begin
                    want = sorted_due.pop_front();
                    if (want.value !== m_tdata || want.last !== m_tlast ||
                        want.ovf !== m_tuser) begin
                        $display("%0t: expected %h last %b ovf %b, got %h last %b ovf %b",
                                 $time, want.value, want.last, want.ovf,
                                 m_tdata, m_tlast, m_tuser);
                        errors++;
                    end
                end
            end
            if (key_taken || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // driver: input beats change at the falling edge
    always @(negedge aclk) begin
        key_beat_t b;
        if (aresetn && (!s_tvalid || key_taken)) begin
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (keys_to_send.size() != 0 && idle_on &&
                         $urandom_range(0, 4) == 0) begin
                send_gap = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end else if (keys_to_send.size() != 0) begin
                b = keys_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b.key;
                s_tlast  <= b.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure in short bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            recv_gap = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        while (stall_cycles < STALL_MAX)
            @(posedge aclk);
        $display("watchdog: no beat moved for %0d cycles", STALL_MAX);
        $display("simulation failed");
        $finish;
    end

    task automatic add_key(ssk_pkg::key_t key, logic last);
        key_beat_t b;
        b.key  = key;
        b.last = last;
        keys_to_send.push_back(b);
        beats_queued++;
    endtask

    function automatic ssk_pkg::key_t pick_key();
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return ssk_pkg::key_t'($urandom_range(0, 7));
            3: return ssk_pkg::key_t'(1) << $urandom_range(0, 31);
            default: return ssk_pkg::key_t'($urandom);
        endcase
    endfunction

    task automatic add_list(int n);
        for (int i = 0; i < n; i++)
            add_key(pick_key(), i == n - 1);
    endtask

    // sender holds off until every beat is in and every result is out
    task automatic wait_drained();
        while (beats_in != beats_queued || sorted_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_order(bit desc);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= desc;
        order_desc   = desc;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int start;
        int r;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, low to high: extremes, single key, equal keys
        set_order(1'b0);
        add_key(32'hFFFF_FFFF, 1'b0);
        add_key(32'h0000_0000, 1'b0);
        add_key(32'h8000_0000, 1'b0);
        add_key(32'h0000_0001, 1'b0);
        add_key(32'h7FFF_FFFF, 1'b1);
        add_key(32'hDEAD_BEEF, 1'b1);
        add_key(32'd5, 1'b0);
        add_key(32'd5, 1'b0);
        add_key(32'd3, 1'b0);
        add_key(32'd5, 1'b1);
        wait_drained();

        // directed, high to low
        set_order(1'b1);
        add_key(32'h0000_0000, 1'b0);
        add_key(32'hFFFF_FFFF, 1'b0);
        add_key(32'hAAAA_AAAA, 1'b0);
        add_key(32'h5555_5555, 1'b0);
        add_key(32'hFFFF_FFFF, 1'b1);
        add_key(32'h0000_0000, 1'b1);
        add_key(32'h0000_0002, 1'b0);
        add_key(32'h0000_0002, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            set_order(ph == 1 || ph == 2);
            idle_on = (ph != 3);
            // full store, key marked last dropped, several dropped
            if (ph == 0) begin
                add_list(LIST_CAP);
                add_list(LIST_CAP + 1);
            end
            if (ph == 2)
                add_list(LIST_CAP + 6);
            start = beats_queued;
            while (beats_queued - start < RAND_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    add_list($urandom_range(1, 12));
                else if (r < 92)
                    add_list($urandom_range(13, LIST_CAP - 1));
                else
                    add_list($urandom_range(LIST_CAP, LIST_CAP + 4));
            end
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        if (sorted_due.size() != 0) begin
            $display("%0t: %0d expected result beats never arrived",
                     $time, sorted_due.size());
            errors++;
        end
        $display("sorted %0d lists (%0d in descending order, %0d with dropped keys)",
                 lists_done, desc_lists, lists_ovf);
        $display("%0d keys loaded, %0d result beats checked, %0d mismatches",
                 beats_in, beats_out, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ssk_pkg.sv
sv/shell_sort_knuth_gaps_top.sv
dv/tb_top.sv
